>>> design/pdr_pkg.sv
package pdr_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    typedef logic signed [19:0] t_speed;
    typedef logic signed [31:0] t_rate;
    typedef logic        [31:0] t_stamp;
    typedef logic signed [47:0] t_pos;
    typedef logic        [31:0] t_angle;
    typedef logic signed [17:0] t_quat;

    // CORDIC datapath word, Q1.30 with headroom
    typedef logic signed [33:0] t_cval;

    // shared multiplier operands and product
    typedef logic signed [32:0] t_mul_a;
    typedef logic signed [19:0] t_mul_b;
    typedef logic signed [52:0] t_prod;

    localparam t_cval CORDIC_GAIN = 34'sd652032874;
    localparam t_cval QUARTER     = 34'sd1073741824;
    localparam t_cval HALF_TURN   = 34'sd2147483648;

    typedef struct packed {
        logic   start;
        t_angle angle;
    } t_cordic_req;

    typedef struct packed {
        logic  busy;
        logic  done;
        t_cval cos;
        t_cval sin;
    } t_cordic_res;

    typedef struct packed {
        logic   en;
        t_mul_a a;
        t_mul_b b;
    } t_mul_req;

    // arctan(2^-i) in units of 2^-32 turn
    function automatic logic [30:0] atan_turn(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:  v = 31'd536870912;
            5'd1:  v = 31'd316933406;
            5'd2:  v = 31'd167458907;
            5'd3:  v = 31'd85004756;
            5'd4:  v = 31'd42667331;
            5'd5:  v = 31'd21354465;
            5'd6:  v = 31'd10679838;
            5'd7:  v = 31'd5340245;
            5'd8:  v = 31'd2670163;
            5'd9:  v = 31'd1335087;
            5'd10: v = 31'd667544;
            5'd11: v = 31'd333772;
            5'd12: v = 31'd166886;
            5'd13: v = 31'd83443;
            5'd14: v = 31'd41722;
            5'd15: v = 31'd20861;
            5'd16: v = 31'd10430;
            5'd17: v = 31'd5215;
            5'd18: v = 31'd2608;
            5'd19: v = 31'd1304;
            5'd20: v = 31'd652;
            5'd21: v = 31'd326;
            5'd22: v = 31'd163;
            5'd23: v = 31'd81;
            5'd24: v = 31'd41;
            5'd25: v = 31'd20;
            5'd26: v = 31'd10;
            5'd27: v = 31'd5;
            5'd28: v = 31'd3;
            5'd29: v = 31'd1;
            5'd30: v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

>>> design/pdr_in_if.sv
interface pdr_in_if;
    logic             valid;
    logic             ready;
    pdr_pkg::t_speed  linear_speed;
    pdr_pkg::t_rate   yaw_rate;
    pdr_pkg::t_stamp  stamp;

    modport source (output valid, output linear_speed, output yaw_rate, output stamp,
                    input ready);
    modport sink   (input valid, input linear_speed, input yaw_rate, input stamp,
                    output ready);
endinterface

>>> design/pdr_out_if.sv
interface pdr_out_if;
    logic             valid;
    logic             ready;
    pdr_pkg::t_pos    pos_x;
    pdr_pkg::t_pos    pos_y;
    pdr_pkg::t_angle  heading_out;
    pdr_pkg::t_quat   quat_z;
    pdr_pkg::t_quat   quat_w;
    pdr_pkg::t_speed  speed_echo;
    pdr_pkg::t_rate   rate_echo;
    pdr_pkg::t_stamp  stamp_echo;

    modport source (output valid, output pos_x, output pos_y, output heading_out,
                    output quat_z, output quat_w, output speed_echo, output rate_echo,
                    output stamp_echo, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading_out,
                    input quat_z, input quat_w, input speed_echo, input rate_echo,
                    input stamp_echo, output ready);
endinterface

>>> design/pdr_mul.sv
module pdr_mul (
    input  logic              i_clk,
    input  pdr_pkg::t_mul_req i_req,
    output pdr_pkg::t_prod    o_prod
);
    import pdr_pkg::*;

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= t_prod'(i_req.a) * t_prod'(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

>>> design/pdr_cordic.sv
module pdr_cordic #(
    parameter int CORDIC_STEPS = pdr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pdr_pkg::t_cordic_req i_req,
    output pdr_pkg::t_cordic_res o_res
);
    import pdr_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);

    logic [IW-1:0] r_i;
    logic          r_busy;
    logic          r_done;
    logic          r_neg;
    t_cval         r_x;
    t_cval         r_y;
    t_cval         r_z;

    t_cval w_z0;
    t_cval w_zf;
    logic  w_negf;
    t_cval w_xs;
    t_cval w_ys;
    t_cval w_at;
    t_cval n_x;
    t_cval n_y;
    t_cval n_z;
    logic  w_last;

    always_comb begin
        // fold angles beyond a quarter turn by a half turn
        w_z0   = t_cval'(signed'(i_req.angle));
        w_zf   = w_z0;
        w_negf = 1'b0;
        if (w_z0 > QUARTER) begin
            w_zf   = w_z0 - HALF_TURN;
            w_negf = 1'b1;
        end else if (w_z0 < -QUARTER) begin
            w_zf   = w_z0 + HALF_TURN;
            w_negf = 1'b1;
        end

        w_xs = r_x >>> r_i;
        w_ys = r_y >>> r_i;
        w_at = t_cval'(atan_turn(5'(r_i)));
        if (!r_z[33]) begin
            n_x = r_x - w_ys;
            n_y = r_y + w_xs;
            n_z = r_z - w_at;
        end else begin
            n_x = r_x + w_ys;
            n_y = r_y - w_xs;
            n_z = r_z + w_at;
        end
        w_last = (r_i == IW'(CORDIC_STEPS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= w_zf;
                r_neg  <= w_negf;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // undo the fold on the last step
                r_x <= (w_last && r_neg) ? -n_x : n_x;
                r_y <= (w_last && r_neg) ? -n_y : n_y;
                r_z <= n_z;
                r_i <= r_i + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.done = r_done;
    assign o_res.cos  = r_x;
    assign o_res.sin  = r_y;

endmodule

>>> design/planar_dead_reckoning_unit.sv
// Channel   Direction  Modport  Payload
// i_in      in         sink     linear_speed, yaw_rate, stamp
// o_out     out        source   pos_x, pos_y, heading_out, quat_z, quat_w,
//                               speed_echo, rate_echo, stamp_echo
//
// Items are taken in one at a time: the input is ready only while idle, so the
// next transfer in waits until the last result has gone to the output register.
// Each item makes two passes through the single iterative CORDIC, with the seven
// steps of the shared 33x20 multiplier after the first and the second overlapping their tail.
// Reset (synchronous, active low) clears position, heading and last stamp to
// zero; no clearing pass is needed. A stalled result sits in the output
// register while the next item is already taken in and worked on.
module planar_dead_reckoning_unit #(
    parameter int CORDIC_STEPS = pdr_pkg::CORDIC_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pdr_in_if.sink    i_in,
    pdr_out_if.source o_out
);
    import pdr_pkg::*;

    // Sequencer: first CORDIC pass on the old heading, then the multiplier
    // chain (distance, heading step, east and north steps), with the second
    // CORDIC pass on half the new heading overlapping the tail of the chain.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORD1,
        ST_M_DIST,
        ST_M_RLO,
        ST_M_RHI,
        ST_M_CLO,
        ST_M_CHI,
        ST_M_SLO,
        ST_M_SHI,
        ST_M_SEND,
        ST_M_NORTH,
        ST_CORD2,
        ST_OUT
    } t_state;

    t_state r_state;

    // model state
    t_pos   r_east;
    t_pos   r_north;
    t_angle r_heading;
    t_stamp r_last;

    // item in flight
    t_speed              r_speed;
    t_rate               r_rate;
    t_stamp              r_stamp;
    logic [31:0]         r_dt;
    logic signed [27:0]  r_cos;
    logic signed [27:0]  r_sin;
    logic signed [37:0]  r_dist;
    logic signed [63:0]  r_acc;

    // output register
    logic   r_out_valid;
    t_pos   r_out_x;
    t_pos   r_out_y;
    t_angle r_out_heading;
    t_quat  r_out_qz;
    t_quat  r_out_qw;
    t_speed r_out_speed;
    t_rate  r_out_rate;
    t_stamp r_out_stamp;

    t_cordic_req w_cor_req;
    t_cordic_res w_cor;
    t_mul_req    w_mul_req;
    t_prod       w_prod;

    logic               w_in_xfer;
    logic               w_out_free;
    logic signed [63:0] w_pext;
    t_prod              w_dsum;
    t_cval              w_cos_rnd;
    t_cval              w_sin_rnd;
    logic signed [39:0] w_dacc;
    logic signed [49:0] w_east_sum;
    logic signed [49:0] w_north_sum;
    t_quat              w_qz;
    t_quat              w_qw;

    // round to Q1.16 and clamp to plus or minus one
    function automatic t_quat quat_of(input t_cval v);
        t_cval              s;
        logic signed [19:0] q;
        t_quat              r;
        s = v + 34'sd8192;
        q = s[33:14];
        if (q > 20'sd65536) begin
            r = 18'sd65536;
        end else if (q < -20'sd65536) begin
            r = -18'sd65536;
        end else begin
            r = q[17:0];
        end
        return r;
    endfunction

    // saturate a widened sum to the 48-bit position range
    function automatic t_pos sat_pos(input logic signed [49:0] v);
        t_pos r;
        if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
            r = v[47:0];
        end else if (v[49]) begin
            r = {1'b1, 47'd0};
        end else begin
            r = {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

    pdr_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_cor_req),
        .o_res  (w_cor)
    );

    pdr_mul u_mul (
        .i_clk (i_clk),
        .i_req (w_mul_req),
        .o_prod(w_prod)
    );

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        w_pext      = 64'(w_prod);
        w_dsum      = w_prod + 53'sd8192;
        w_cos_rnd   = w_cor.cos + 34'sd32;
        w_sin_rnd   = w_cor.sin + 34'sd32;
        w_dacc      = r_acc[63:24];
        w_east_sum  = 50'(r_east) + 50'(w_dacc);
        w_north_sum = 50'(r_north) + 50'(w_dacc);
        w_qz        = quat_of(w_cor.sin);
        w_qw        = quat_of(w_cor.cos);
    end

    // CORDIC starts: old heading on transfer in, half the new heading later
    always_comb begin
        w_cor_req.start = 1'b0;
        w_cor_req.angle = r_heading;
        if (r_state == ST_IDLE && w_in_xfer) begin
            w_cor_req.start = 1'b1;
        end else if (r_state == ST_M_SLO) begin
            w_cor_req.start = 1'b1;
            w_cor_req.angle = {1'b0, r_heading[31:1]};
        end
    end

    // multiplier operand select
    always_comb begin
        w_mul_req.en = 1'b1;
        w_mul_req.a  = '0;
        w_mul_req.b  = '0;
        case (r_state)
            ST_M_DIST: begin
                w_mul_req.a = {1'b0, r_dt};
                w_mul_req.b = r_speed;
            end
            ST_M_RLO: begin
                w_mul_req.a = {r_rate[31], r_rate};
                w_mul_req.b = {4'd0, r_dt[15:0]};
            end
            ST_M_RHI: begin
                w_mul_req.a = {r_rate[31], r_rate};
                w_mul_req.b = {4'd0, r_dt[31:16]};
            end
            ST_M_CLO: begin
                w_mul_req.a = 33'(r_cos);
                w_mul_req.b = {1'b0, r_dist[18:0]};
            end
            ST_M_CHI: begin
                w_mul_req.a = 33'(r_cos);
                w_mul_req.b = {r_dist[37], r_dist[37:19]};
            end
            ST_M_SLO: begin
                w_mul_req.a = 33'(r_sin);
                w_mul_req.b = {1'b0, r_dist[18:0]};
            end
            ST_M_SHI: begin
                w_mul_req.a = 33'(r_sin);
                w_mul_req.b = {r_dist[37], r_dist[37:19]};
            end
            default: begin
                w_mul_req.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_east      <= '0;
            r_north     <= '0;
            r_heading   <= '0;
            r_last      <= '0;
        end else begin
            // drop the result once it has been transferred
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_speed <= i_in.linear_speed;
                        r_rate  <= i_in.yaw_rate;
                        r_stamp <= i_in.stamp;
                        r_dt    <= i_in.stamp - r_last;
                        r_last  <= i_in.stamp;
                        r_state <= ST_CORD1;
                    end
                end
                ST_CORD1: begin
                    // hold cos and sin of the old heading in Q.24
                    if (w_cor.done) begin
                        r_cos   <= w_cos_rnd[33:6];
                        r_sin   <= w_sin_rnd[33:6];
                        r_state <= ST_M_DIST;
                    end
                end
                ST_M_DIST: begin
                    r_state <= ST_M_RLO;
                end
                ST_M_RLO: begin
                    r_dist  <= w_dsum[51:14];
                    r_state <= ST_M_RHI;
                end
                ST_M_RHI: begin
                    r_acc   <= w_pext + 64'sd2048;
                    r_state <= ST_M_CLO;
                end
                ST_M_CLO: begin
                    r_acc   <= r_acc + (w_pext <<< 16);
                    r_state <= ST_M_CHI;
                end
                ST_M_CHI: begin
                    // advance heading, wrapping a full turn
                    r_heading <= r_heading + r_acc[43:12];
                    r_acc     <= w_pext + 64'sd8388608;
                    r_state   <= ST_M_SLO;
                end
                ST_M_SLO: begin
                    r_acc   <= r_acc + (w_pext <<< 19);
                    r_state <= ST_M_SHI;
                end
                ST_M_SHI: begin
                    r_east  <= sat_pos(w_east_sum);
                    r_acc   <= w_pext + 64'sd8388608;
                    r_state <= ST_M_SEND;
                end
                ST_M_SEND: begin
                    r_acc   <= r_acc + (w_pext <<< 19);
                    r_state <= ST_M_NORTH;
                end
                ST_M_NORTH: begin
                    r_north <= sat_pos(w_north_sum);
                    r_state <= ST_CORD2;
                end
                ST_CORD2: begin
                    if (w_cor.done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // CORDIC results hold until the next start
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_x       <= r_east;
                        r_out_y       <= r_north;
                        r_out_heading <= r_heading;
                        r_out_qz      <= w_qz;
                        r_out_qw      <= w_qw;
                        r_out_speed   <= r_speed;
                        r_out_rate    <= r_rate;
                        r_out_stamp   <= r_stamp;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.pos_x       = r_out_x;
    assign o_out.pos_y       = r_out_y;
    assign o_out.heading_out = r_out_heading;
    assign o_out.quat_z      = r_out_qz;
    assign o_out.quat_w      = r_out_qw;
    assign o_out.speed_echo  = r_out_speed;
    assign o_out.rate_echo   = r_out_rate;
    assign o_out.stamp_echo  = r_out_stamp;

    // CORDIC finishes only where the sequencer waits for it
    a_cordic_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cor.done |-> (r_state == ST_CORD1 || r_state == ST_CORD2))
        else $error("CORDIC finished outside a wait state");

    // no transfer in while the CORDIC still runs
    a_in_cordic_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |-> !w_cor.busy)
        else $error("input transfer while CORDIC busy");

    // second pass starts on an idle CORDIC
    a_second_pass_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_M_SLO) |-> !w_cor.busy)
        else $error("second CORDIC pass started while busy");

    // a result appears only from the output step
    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result raised outside output step");

endmodule
